@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the shift/rotate unit RTL.
// No dependencies; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside of reset.
`define SRU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside of reset.
`define SRU_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `SRU_ASSERT(lbl, clk, rst, !(expr), msg)

`else

`define SRU_ASSERT(lbl, clk, rst, prop, msg)
`define SRU_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

@@ rtl/core/sru_pkg.sv @@
// Package for the shift/rotate unit: widths, operation kinds, size helpers
// and the structs passed between the sequencer and the one-bit step unit.
// No dependencies.
package sru_pkg;

   localparam int DATA_W  = 32;
   localparam int OP_W    = 3;
   localparam int SIZE_W  = 2;
   localparam int CNTF_W  = 3;
   localparam int CNT_W   = 6;

   // Operation family, taken from the upper two opcode bits.
   typedef enum logic [1:0] {
      KIND_ARITH = 2'd0,
      KIND_LOGIC = 2'd1,
      KIND_ROTX  = 2'd2,
      KIND_ROT   = 2'd3
   } kind_type;

   localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd1;

   typedef struct packed {
      kind_type            kind;
      logic                left;
      logic [SIZE_W-1:0]   size;
   } step_ctrl_type;

   typedef struct packed {
      logic [DATA_W-1:0]   v;
      logic                x;
      logic                last;
      logic                vflag;
   } step_state_type;

   // Any size code other than byte or word acts as long.
   function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
      logic [DATA_W-1:0] m;
      case (size)
         SIZE_BYTE: m = 32'h0000_00FF;
         SIZE_WORD: m = 32'h0000_FFFF;
         default:   m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic [DATA_W-1:0] size_msb(input logic [SIZE_W-1:0] size);
      logic [DATA_W-1:0] m;
      case (size)
         SIZE_BYTE: m = 32'h0000_0080;
         SIZE_WORD: m = 32'h0000_8000;
         default:   m = 32'h8000_0000;
      endcase
      return m;
   endfunction

endpackage

@@ rtl/core/sru_step.sv @@
// One-bit shift/rotate step of the shift/rotate unit.
// Depends on sru_pkg.
module sru_step (
   input  sru_pkg::step_ctrl_type   ctrl,
   input  logic                     sign,
   input  sru_pkg::step_state_type  cur,
   output sru_pkg::step_state_type  nxt
);
   import sru_pkg::*;

   logic [DATA_W-1:0] mask;
   logic [DATA_W-1:0] msb;
   logic [DATA_W-1:0] sh;
   logic              top;
   logic              new_top;

   always_comb begin
      mask    = size_mask(ctrl.size);
      msb     = size_msb(ctrl.size);
      top     = |(cur.v & msb);
      nxt     = cur;
      sh      = '0;
      new_top = 1'b0;
      if (ctrl.left) begin
         nxt.last = top;
         sh       = (cur.v << 1) & mask;
         new_top  = |(sh & msb);
         case (ctrl.kind)
            KIND_ARITH: begin
               if (top != new_top) nxt.vflag = 1'b1;
            end
            KIND_ROTX: begin
               sh    = sh | {{(DATA_W-1){1'b0}}, cur.x};
               nxt.x = top;
            end
            KIND_ROT: sh = sh | {{(DATA_W-1){1'b0}}, top};
            default: ;
         endcase
      end else begin
         nxt.last = cur.v[0];
         sh       = cur.v >> 1;
         case (ctrl.kind)
            KIND_ARITH: begin
               if (sign) sh = sh | msb;
            end
            KIND_ROTX: begin
               if (cur.x) sh = sh | msb;
               nxt.x = cur.v[0];
            end
            KIND_ROT: begin
               if (cur.v[0]) sh = sh | msb;
            end
            default: ;
         endcase
      end
      nxt.v = sh;
   end

endmodule

@@ rtl/core/shift_rotate_unit.sv @@
// Shift/rotate unit in the style of a 68000 integer core: ASR, ASL, LSR,
// LSL, ROXR, ROXL, ROR and ROL on the byte, word or long part of a 32-bit
// operand, with the X, N, Z, V and C flags. Depends on sru_pkg, sru_step
// and assert_macros.svh.
//
// A request beat carries the opcode, size, count source and operand. The
// unit moves the operand by one bit per clock through a single shared step
// unit, for a shift count N (0 to 63 from a register, 1 to 8 from the
// immediate field, where 0 means 8): the run state takes one step per bit,
// then the flags state forms the flags and the merged result, and the output
// state presents the response beat. The unit works on one item at a time;
// req_ready rises again in the clock after the response beat is taken.
// Bits above the operand size pass through unchanged.
module shift_rotate_unit (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sru_pkg::OP_W-1:0]      req_opcode,
   input  logic [sru_pkg::SIZE_W-1:0]    req_size,
   input  logic                          req_count_from_register,
   input  logic [sru_pkg::CNTF_W-1:0]    req_count_field,
   input  logic [sru_pkg::DATA_W-1:0]    req_count_register_value,
   input  logic [sru_pkg::DATA_W-1:0]    req_operand,
   input  logic                          req_x_in,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sru_pkg::DATA_W-1:0]    rsp_result,
   output logic                          rsp_x_out,
   output logic                          rsp_n_out,
   output logic                          rsp_z_out,
   output logic                          rsp_v_out,
   output logic                          rsp_c_out
);
   import sru_pkg::*;

`include "assert_macros.svh"

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_FLAGS = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               cnt_zero_ff, cnt_zero_in;
   step_ctrl_type      ctrl_ff, ctrl_in;
   step_state_type     work_ff, work_in;
   step_state_type     step_out;
   logic               sign_ff, sign_in;
   logic [DATA_W-1:0]  operand_ff, operand_in;

   logic [DATA_W-1:0]  result_ff, result_in;
   logic               x_out_ff, x_out_in;
   logic               n_out_ff, n_out_in;
   logic               z_out_ff, z_out_in;
   logic               v_out_ff, v_out_in;
   logic               c_out_ff, c_out_in;

   logic [CNT_W-1:0]   load_cnt;
   logic [DATA_W-1:0]  mask;
   logic [DATA_W-1:0]  msb;
   logic [DATA_W-1:0]  req_mask;
   logic               req_beat;
   logic               shift_kind;

   // The single shared step unit; the sequencer feeds its output back into
   // the working registers once per clock while the count runs down.
   sru_step u_step (
      .ctrl (ctrl_ff),
      .sign (sign_ff),
      .cur  (work_ff),
      .nxt  (step_out)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_beat  = req_valid && req_ready;

   assign rsp_result = result_ff;
   assign rsp_x_out  = x_out_ff;
   assign rsp_n_out  = n_out_ff;
   assign rsp_z_out  = z_out_ff;
   assign rsp_v_out  = v_out_ff;
   assign rsp_c_out  = c_out_ff;

   // Register counts use the low six bits; an immediate zero stands for eight.
   always_comb begin
      if (req_count_from_register) begin
         load_cnt = req_count_register_value[CNT_W-1:0];
      end else if (req_count_field == '0) begin
         load_cnt = CNT_W'(8);
      end else begin
         load_cnt = CNT_W'(req_count_field);
      end
   end

   assign req_mask   = size_mask(req_size);
   assign mask       = size_mask(ctrl_ff.size);
   assign msb        = size_msb(ctrl_ff.size);
   assign shift_kind = (ctrl_ff.kind == KIND_ARITH) || (ctrl_ff.kind == KIND_LOGIC);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cnt_zero_in = cnt_zero_ff;
      ctrl_in     = ctrl_ff;
      work_in     = work_ff;
      sign_in     = sign_ff;
      operand_in  = operand_ff;
      result_in   = result_ff;
      x_out_in    = x_out_ff;
      n_out_in    = n_out_ff;
      z_out_in    = z_out_ff;
      v_out_in    = v_out_ff;
      c_out_in    = c_out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               ctrl_in.kind  = kind_type'(req_opcode[OP_W-1:1]);
               ctrl_in.left  = req_opcode[0];
               ctrl_in.size  = req_size;
               operand_in    = req_operand;
               work_in.v     = req_operand & req_mask;
               work_in.x     = req_x_in;
               work_in.last  = 1'b0;
               work_in.vflag = 1'b0;
               sign_in       = |(req_operand & size_msb(req_size));
               cnt_in        = load_cnt;
               cnt_zero_in   = (load_cnt == '0);
               state_in      = (load_cnt == '0) ? ST_FLAGS : ST_RUN;
            end
         end
         ST_RUN: begin
            work_in = step_out;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) state_in = ST_FLAGS;
         end
         ST_FLAGS: begin
            // The last bit out is still zero when no step ran, which gives
            // the zero-count carry of shifts and plain rotates for free.
            result_in = (operand_ff & ~mask) | work_ff.v;
            n_out_in  = |(work_ff.v & msb);
            z_out_in  = (work_ff.v == '0);
            v_out_in  = work_ff.vflag;
            if (ctrl_ff.kind == KIND_ROTX) begin
               c_out_in = work_ff.x;
               x_out_in = work_ff.x;
            end else if (shift_kind && !cnt_zero_ff) begin
               c_out_in = work_ff.last;
               x_out_in = work_ff.last;
            end else begin
               // Plain rotates and zero-count shifts keep the incoming X.
               c_out_in = work_ff.last;
               x_out_in = work_ff.x;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      cnt_zero_ff <= cnt_zero_in;
      ctrl_ff     <= ctrl_in;
      work_ff     <= work_in;
      sign_ff     <= sign_in;
      operand_ff  <= operand_in;
      result_ff   <= result_in;
      x_out_ff    <= x_out_in;
      n_out_ff    <= n_out_in;
      z_out_ff    <= z_out_in;
      v_out_ff    <= v_out_in;
      c_out_ff    <= c_out_in;
   end

   // The unit never offers a new request slot while a response is pending.
   `SRU_ASSERT_NEVER(a_one_item, clock, reset, req_ready && rsp_valid, "ready while response pending")
   // The bit loop only runs with steps left to do.
   `SRU_ASSERT_NEVER(a_run_cnt, clock, reset, (state_ff == ST_RUN) && (cnt_ff == '0), "run with zero count")
   // A request beat closes the request side on the next clock.
   `SRU_ASSERT(a_busy_after_req, clock, reset, req_beat |=> !req_ready, "ready right after request beat")
   // A taken response reopens the request side on the next clock.
   `SRU_ASSERT(a_ready_after_rsp, clock, reset, (rsp_valid && rsp_ready) |=> req_ready, "not ready after response beat")
   // Overflow can only come from an arithmetic left shift.
   `SRU_ASSERT(a_v_only_asl, clock, reset, (rsp_valid && !((ctrl_ff.kind == KIND_ARITH) && ctrl_ff.left)) |-> !rsp_v_out, "V set outside ASL")

endmodule

@@ bench/tb_shift_rotate_unit.sv @@
// Self-checking testbench for shift_rotate_unit: a directed table of shift and rotate
// beats, then constrained-free random traffic, scored by hand or an in-bench predictor.
// Depends on sru_pkg and the shift_rotate_unit RTL.
module tb_shift_rotate_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import sru_pkg::*;

   // Operation codes as carried in req_opcode.
   typedef enum logic [OP_W-1:0] {
      OP_ASR  = 3'd0,
      OP_ASL  = 3'd1,
      OP_LSR  = 3'd2,
      OP_LSL  = 3'd3,
      OP_ROXR = 3'd4,
      OP_ROXL = 3'd5,
      OP_ROR  = 3'd6,
      OP_ROL  = 3'd7
   } shift_op_type;

   // The package names byte and word; long and the spare code are added here.
   localparam logic [SIZE_W-1:0] SIZE_LONG  = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_SPARE = 2'd3;

   localparam int NUM_RANDOM   = 2000;
   localparam int DRAIN_CYCLES = 70;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      shift_op_type        opcode;
      logic [SIZE_W-1:0]   size;
      logic                from_reg;
      logic [CNTF_W-1:0]   field;
      logic [DATA_W-1:0]   count_reg;
      logic [DATA_W-1:0]   operand;
      logic                x_in;
   } shift_req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   result;
      logic                x;
      logic                n;
      logic                z;
      logic                v;
      logic                c;
   } shift_rsp_type;

   // One row of the directed table. Rows marked known carry an expectation that
   // was worked out by hand; the others are scored by the predictor.
   typedef struct packed {
      shift_req_type       req;
      logic                known;
      shift_rsp_type       hand;
   } table_row_type;

   // All block inputs start at a known value; the drivers below only use
   // nonblocking assignments at the rising edge.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [SIZE_W-1:0]   req_size = '0;
   logic                req_count_from_register = 1'b0;
   logic [CNTF_W-1:0]   req_count_field = '0;
   logic [DATA_W-1:0]   req_count_register_value = '0;
   logic [DATA_W-1:0]   req_operand = '0;
   logic                req_x_in = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W-1:0]   rsp_result;
   logic                rsp_x_out;
   logic                rsp_n_out;
   logic                rsp_z_out;
   logic                rsp_v_out;
   logic                rsp_c_out;

   shift_rsp_type       results_due[$];
   table_row_type       directed_rows[$];
   int                  cycle_count = 0;
   int                  items_sent = 0;
   int                  results_seen = 0;
   int                  mismatch_count = 0;
   int                  stall_left = 0;

   shift_rotate_unit uut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_opcode               (req_opcode),
      .req_size                 (req_size),
      .req_count_from_register  (req_count_from_register),
      .req_count_field          (req_count_field),
      .req_count_register_value (req_count_register_value),
      .req_operand              (req_operand),
      .req_x_in                 (req_x_in),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_result               (rsp_result),
      .rsp_x_out                (rsp_x_out),
      .rsp_n_out                (rsp_n_out),
      .rsp_z_out                (rsp_z_out),
      .rsp_v_out                (rsp_v_out),
      .rsp_c_out                (rsp_c_out)
   );

   always #6 clock = ~clock;

   // Predicts one response beat. The operand is moved one bit per step, exactly
   // as the hardware does, so counts beyond the operand size need no special case.
   function automatic shift_rsp_type predict_shift(input shift_req_type r);
      kind_type            kind;
      logic                left;
      logic [DATA_W-1:0]   mask;
      logic [DATA_W-1:0]   msb;
      logic [DATA_W-1:0]   val;
      logic [DATA_W-1:0]   sign;
      logic                x;
      logic                last;
      logic                ovf;
      int                  steps;
      int                  i;
      shift_rsp_type       p;
      kind = kind_type'(r.opcode[2:1]);
      left = r.opcode[0];
      case (r.size)
         SIZE_BYTE: begin
            mask = 32'h0000_00FF;
            msb  = 32'h0000_0080;
         end
         SIZE_WORD: begin
            mask = 32'h0000_FFFF;
            msb  = 32'h0000_8000;
         end
         default: begin
            mask = 32'hFFFF_FFFF;
            msb  = 32'h8000_0000;
         end
      endcase
      if (r.from_reg) steps = int'(r.count_reg[CNT_W-1:0]);
      else steps = (r.field == '0) ? 8 : int'(r.field);
      val  = r.operand & mask;
      sign = val & msb;
      x    = r.x_in;
      last = 1'b0;
      ovf  = 1'b0;
      for (i = 0; i < steps; i++) begin
         if (left) begin
            last = |(val & msb);
            val  = (val << 1) & mask;
            case (kind)
               KIND_ARITH: if (last != |(val & msb)) ovf = 1'b1;
               KIND_ROTX: begin
                  val[0] = x;
                  x = last;
               end
               KIND_ROT: val[0] = last;
               default: ;
            endcase
         end else begin
            last = val[0];
            val  = val >> 1;
            case (kind)
               KIND_ARITH: val = val | sign;
               KIND_ROTX: begin
                  if (x) val = val | msb;
                  x = last;
               end
               KIND_ROT: if (last) val = val | msb;
               default: ;
            endcase
         end
      end
      // A zero count leaves X alone for shifts; rotates through X report X in C;
      // plain rotates never touch X.
      case (kind)
         KIND_ARITH, KIND_LOGIC: begin
            p.c = (steps > 0) ? last : 1'b0;
            p.x = (steps > 0) ? last : r.x_in;
         end
         KIND_ROTX: begin
            p.c = x;
            p.x = x;
         end
         default: begin
            p.c = (steps > 0) ? last : 1'b0;
            p.x = r.x_in;
         end
      endcase
      p.result = (r.operand & ~mask) | val;
      p.n = |(val & msb);
      p.z = (val == '0);
      p.v = ovf;
      return p;
   endfunction

   function automatic shift_req_type mk_req(input shift_op_type op,
                                            input logic [SIZE_W-1:0] size,
                                            input logic from_reg,
                                            input logic [CNTF_W-1:0] field,
                                            input logic [DATA_W-1:0] count_reg,
                                            input logic [DATA_W-1:0] operand,
                                            input logic x_in);
      shift_req_type r;
      r.opcode    = op;
      r.size      = size;
      r.from_reg  = from_reg;
      r.field     = field;
      r.count_reg = count_reg;
      r.operand   = operand;
      r.x_in      = x_in;
      return r;
   endfunction

   function automatic shift_rsp_type mk_rsp(input logic [DATA_W-1:0] result, input logic x,
                                            input logic n, input logic z, input logic v,
                                            input logic c);
      shift_rsp_type p;
      p.result = result;
      p.x = x;
      p.n = n;
      p.z = z;
      p.v = v;
      p.c = c;
      return p;
   endfunction

   task automatic add_row(input shift_req_type r);
      table_row_type row;
      row.req   = r;
      row.known = 1'b0;
      row.hand  = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_known(input shift_req_type r, input shift_rsp_type e);
      table_row_type row;
      row.req   = r;
      row.known = 1'b1;
      row.hand  = e;
      directed_rows.push_back(row);
   endtask

   // Sender idle length. Every fourth block of 150 beats runs back to back so that
   // the unit also sees a request waiting the moment it frees up.
   function automatic int req_gap(input int idx);
      int roll;
      if (((idx / 150) % 4) == 3) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Presents one request beat and holds it until the unit takes it. Called at a
   // rising edge and returns at the edge of acceptance, so that a following beat
   // with no gap keeps valid high without a glitch.
   task automatic send_shift(input shift_req_type r, input int gap, input logic known,
                             input shift_rsp_type hand);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_opcode               <= r.opcode;
      req_size                 <= r.size;
      req_count_from_register  <= r.from_reg;
      req_count_field          <= r.field;
      req_count_register_value <= r.count_reg;
      req_operand              <= r.operand;
      req_x_in                 <= r.x_in;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      results_due.push_back(known ? hand : predict_shift(r));
   endtask

   // Receiver back-pressure. Stalls are mostly short with the odd long one, and
   // one window in four of the cycle count never stalls at all.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!reset && (((cycle_count / 4000) % 4) != 1)) begin
            case ($urandom_range(0, 99)) inside
               [0:19]:  stall_left = $urandom_range(1, 3);
               [20:22]: stall_left = $urandom_range(10, 30);
               default: stall_left = 0;
            endcase
         end
      end
   end

   // Scoreboard. Outputs are sampled at the edge, before any of this edge's
   // updates land, so the order of processes within the step does not matter.
   always @(posedge clock) begin
      shift_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("result beat %0d arrived with nothing outstanding: result %h",
                        results_seen, rsp_result);
         end else begin
            want = results_due.pop_front();
            if (rsp_result !== want.result || rsp_x_out !== want.x ||
                rsp_n_out !== want.n || rsp_z_out !== want.z ||
                rsp_v_out !== want.v || rsp_c_out !== want.c) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("mismatch on result beat %0d: expected %h X%b N%b Z%b V%b C%b",
                           results_seen, want.result, want.x, want.n, want.z, want.v,
                           want.c);
                  $display("                            actual   %h X%b N%b Z%b V%b C%b",
                           rsp_result, rsp_x_out, rsp_n_out, rsp_z_out, rsp_v_out,
                           rsp_c_out);
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, results_due.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      shift_req_type       r;
      logic [DATA_W-1:0]   operand;
      logic [DATA_W-1:0]   count_reg;
      logic [SIZE_W-1:0]   size;
      int                  width;
      int                  roll;
      int                  n;

      // Synchronous reset, held high from time zero and then released.
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Hand-typed rows: zero counts of logical shifts and both rotates, a
      // register count of 64 that wraps to zero, counts equal to and beyond the operand
      // size, sign fill, overflow on arithmetic left, and the spare size code.
      add_known(mk_req(OP_LSL, SIZE_LONG, 1'b1, 3'd0, 32'h0000_0040, 32'hFFFF_FFFF, 1'b1),
                mk_rsp(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
      add_known(mk_req(OP_ROXL, SIZE_BYTE, 1'b1, 3'd5, 32'h0000_0000, 32'h1234_5600, 1'b1),
                mk_rsp(32'h1234_5600, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
      add_known(mk_req(OP_ROR, SIZE_WORD, 1'b1, 3'd2, 32'h0000_0000, 32'hABCD_0000, 1'b1),
                mk_rsp(32'hABCD_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
      add_known(mk_req(OP_LSR, SIZE_LONG, 1'b1, 3'd0, 32'h0000_0028, 32'hFFFF_FFFF, 1'b1),
                mk_rsp(32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      add_known(mk_req(OP_ASR, SIZE_BYTE, 1'b1, 3'd0, 32'h0000_003F, 32'hAAAA_AA80, 1'b0),
                mk_rsp(32'hAAAA_AAFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
      add_known(mk_req(OP_ASL, SIZE_BYTE, 1'b0, 3'd1, 32'hFFFF_FFFF, 32'h0000_0040, 1'b1),
                mk_rsp(32'h0000_0080, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
      add_known(mk_req(OP_LSL, SIZE_WORD, 1'b0, 3'd0, 32'h0000_0000, 32'hFFFF_00FF, 1'b0),
                mk_rsp(32'hFFFF_FF00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      add_known(mk_req(OP_LSL, SIZE_LONG, 1'b1, 3'd0, 32'h0000_0020, 32'h0000_0001, 1'b0),
                mk_rsp(32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
      add_known(mk_req(OP_ROXR, SIZE_SPARE, 1'b1, 3'd0, 32'h0000_0000, 32'h8000_0000, 1'b1),
                mk_rsp(32'h8000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
      // Every operation by one on a long with both end bits set.
      for (n = 0; n < 8; n++)
         add_row(mk_req(shift_op_type'(n), SIZE_LONG, 1'b0, 3'd1, 32'h0, 32'h8000_0001, 1'b1));
      // Full circle through X, odd word count, byte rotate by eight, maximum
      // register count, immediate field seven, spare size, and an ignored register.
      add_row(mk_req(OP_ROXL, SIZE_LONG, 1'b1, 3'd0, 32'h0000_0021, 32'hDEAD_BEEF, 1'b0));
      add_row(mk_req(OP_ROXR, SIZE_WORD, 1'b1, 3'd0, 32'h0000_0011, 32'h1234_F00F, 1'b1));
      add_row(mk_req(OP_ROL, SIZE_BYTE, 1'b0, 3'd0, 32'h0000_0000, 32'hFFFF_FF5A, 1'b0));
      add_row(mk_req(OP_ASL, SIZE_LONG, 1'b1, 3'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0));
      add_row(mk_req(OP_ASR, SIZE_WORD, 1'b0, 3'd7, 32'h0000_0000, 32'h0000_8001, 1'b0));
      add_row(mk_req(OP_ROR, SIZE_SPARE, 1'b1, 3'd0, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0));
      add_row(mk_req(OP_LSR, SIZE_BYTE, 1'b0, 3'd3, 32'hFFFF_FFC9, 32'hFFFF_FFFF, 1'b1));

      foreach (directed_rows[i])
         send_shift(directed_rows[i].req, req_gap(i), directed_rows[i].known,
                    directed_rows[i].hand);

      // Random traffic. Sizes lean on the three real codes with the spare code now
      // and then; register counts often land right around the operand width.
      for (n = 0; n < NUM_RANDOM; n++) begin
         roll = $urandom_range(0, 15);
         size = (roll == 15) ? SIZE_SPARE : SIZE_W'(roll % 3);
         width = (size == SIZE_BYTE) ? 8 : (size == SIZE_WORD) ? 16 : 32;
         count_reg = $urandom;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
               0:       count_reg[CNT_W-1:0] = '0;
               1:       count_reg[CNT_W-1:0] = 6'd1;
               2:       count_reg[CNT_W-1:0] = CNT_W'(width - 1);
               3:       count_reg[CNT_W-1:0] = CNT_W'(width);
               default: count_reg[CNT_W-1:0] = CNT_W'(width + 1);
            endcase
         end
         case ($urandom_range(0, 9))
            0:       operand = '0;
            1:       operand = '1;
            2:       operand = 32'h8000_8080;
            3:       operand = 32'h7FFF_7F7F;
            default: operand = $urandom;
         endcase
         r = mk_req(shift_op_type'($urandom_range(0, 7)), size, 1'($urandom_range(0, 1)),
                    3'($urandom_range(0, 7)), count_reg, operand, 1'($urandom_range(0, 1)));
         send_shift(r, req_gap(n + directed_rows.size()), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Drain, then allow for one more worst-case item in flight.
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (results_due.size() != 0) begin
         mismatch_count++;
         $display("%0d expected results never arrived", results_due.size());
      end
      $display("Sent %0d request beats (%0d directed, %0d typed by hand), checked %0d results",
               items_sent, directed_rows.size(), 9, results_seen);
      $display("over all eight operations, three sizes plus the spare code, counts 0 to 63");
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d failures", mismatch_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
